// File: rtl/fft_size_smooth_search_defines.svh
// Assertion macros for the length search block.
`ifndef FFT_SIZE_SMOOTH_SEARCH_DEFINES_SVH
`define FFT_SIZE_SMOOTH_SEARCH_DEFINES_SVH

// same-cycle implication
`define FSS_ASSERT_NOW(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// next-cycle implication
`define FSS_ASSERT_NEXT(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

// File: rtl/fss_pkg.sv
package fss_pkg;

    localparam int LEN_BITS_DEF = 24;

    // inverse of an odd number modulo 2^64 (Newton iteration)
    function automatic logic [63:0] odd_inverse(input logic [63:0] p);
        logic [63:0] x;
        x = p;
        for (int i = 0; i < 6; i++)
        begin
            x = x * (64'd2 - p * x);
        end
        return x;
    endfunction

endpackage

// File: rtl/fft_size_smooth_search.sv
// Smooth transform length search.
// Input channel: request_len with in_valid / in_stall. An item is taken when
// in_valid is high and in_stall is low; in_stall stays high while an item is
// being searched or its result cannot yet be moved to the output register.
// Output channel: chosen_len, extension, search_failed with out_valid /
// out_stall. One result item per input item, one item in work at a time.
// Candidates request_len .. request_len + max(3, request_len/20) are tried in
// order. Each candidate is loaded, its factors of two are shifted out to find
// the odd part, each factor of 3, 5 or 7 is removed by a multiply step and a
// check step, the three failed divisibility tests follow and then the final
// check; a candidate of 0 or 1 is skipped at load. All divisions
// by 3, 5 and 7 go through a single shared multiplier (exact division by
// modular inverse), so the search time is data dependent. On failure the
// window end is seen at load; the done state hands results to the output register.
// A held result waits in the output register while out_stall is high; the
// next item may be accepted and searched meanwhile, and its result waits
// internally until the output register frees up.
// Reset (rst_n low, asynchronous) returns the sequencer to idle and clears
// out_valid.
`include "fft_size_smooth_search_defines.svh"

module fft_size_smooth_search #(
    parameter int LEN_BITS = fss_pkg::LEN_BITS_DEF
) (
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  in_valid,
    output logic                  in_stall,
    input  logic [LEN_BITS-1:0]   request_len,
    output logic                  out_valid,
    input  logic                  out_stall,
    output logic [LEN_BITS:0]     chosen_len,
    output logic [LEN_BITS-5:0]   extension,
    output logic                  search_failed
);

    localparam int W  = LEN_BITS + 1;
    localparam int EW = LEN_BITS - 4;

    localparam logic [2:0] S_IDLE = 3'd0;
    localparam logic [2:0] S_LOAD = 3'd1;
    localparam logic [2:0] S_TWO  = 3'd2;
    localparam logic [2:0] S_MUL  = 3'd3;
    localparam logic [2:0] S_CHK  = 3'd4;
    localparam logic [2:0] S_END  = 3'd5;
    localparam logic [2:0] S_DONE = 3'd6;

    localparam logic [1:0] P3 = 2'd0;
    localparam logic [1:0] P5 = 2'd1;
    localparam logic [1:0] P7 = 2'd2;

    localparam logic [63:0] INV3_FULL = fss_pkg::odd_inverse(64'd3);
    localparam logic [63:0] INV5_FULL = fss_pkg::odd_inverse(64'd5);
    localparam logic [63:0] INV7_FULL = fss_pkg::odd_inverse(64'd7);
    localparam logic [W-1:0] INV3 = INV3_FULL[W-1:0];
    localparam logic [W-1:0] INV5 = INV5_FULL[W-1:0];
    localparam logic [W-1:0] INV7 = INV7_FULL[W-1:0];
    localparam logic [W-1:0] W_MASK = {W{1'b1}};
    localparam logic [W-1:0] LIM3 = W'(W_MASK / 3);
    localparam logic [W-1:0] LIM5 = W'(W_MASK / 5);
    localparam logic [W-1:0] LIM7 = W'(W_MASK / 7);
    localparam logic [EW-1:0] MIN_EXT = EW'(3);

    logic [2:0]          state_reg, state_next;
    logic [LEN_BITS-1:0] req_reg, req_next;
    logic [EW-1:0]       ext_reg, ext_next;
    logic [W-1:0]        n_reg, n_next;
    logic [W-1:0]        prod_reg, prod_next;
    logic [1:0]          pidx_reg, pidx_next;
    logic                fail_reg, fail_next;
    logic                out_valid_reg, out_valid_next;
    logic [W-1:0]        chosen_reg, chosen_next;
    logic [EW-1:0]       ext_out_reg, ext_out_next;
    logic                failed_out_reg, failed_out_next;

    logic [W-1:0]        cand;
    logic [W:0]          ext_x20;
    logic                in_window;
    logic [W-1:0]        inv_sel;
    logic [W-1:0]        lim_sel;
    logic [W-1:0]        prod_full;

    assign cand      = {1'b0, req_reg} + W'(ext_reg);
    assign ext_x20   = ({(W+1-EW)'(0), ext_reg} << 4) + ({(W+1-EW)'(0), ext_reg} << 2);
    assign in_window = (ext_reg <= MIN_EXT) || (ext_x20 <= {2'b00, req_reg});

    always_comb
    begin
        case (pidx_reg)
            P3:
            begin
                inv_sel = INV3;
                lim_sel = LIM3;
            end
            P5:
            begin
                inv_sel = INV5;
                lim_sel = LIM5;
            end
            default:
            begin
                inv_sel = INV7;
                lim_sel = LIM7;
            end
        endcase
    end

    assign prod_full = n_reg * inv_sel;

    always_comb
    begin
        state_next      = state_reg;
        req_next        = req_reg;
        ext_next        = ext_reg;
        n_next          = n_reg;
        prod_next       = prod_reg;
        pidx_next       = pidx_reg;
        fail_next       = fail_reg;
        out_valid_next  = out_valid_reg && out_stall;
        chosen_next     = chosen_reg;
        ext_out_next    = ext_out_reg;
        failed_out_next = failed_out_reg;
        case (state_reg)
            S_IDLE:
            begin
                if (in_valid)
                begin
                    req_next   = request_len;
                    ext_next   = '0;
                    state_next = S_LOAD;
                end
            end
            S_LOAD:
            begin
                if (!in_window)
                begin
                    fail_next  = 1'b1;
                    state_next = S_DONE;
                end
                else if (cand <= W'(1))
                begin
                    ext_next = ext_reg + EW'(1);
                end
                else
                begin
                    n_next     = cand;
                    pidx_next  = P3;
                    state_next = S_TWO;
                end
            end
            S_TWO:
            begin
                if (!n_reg[0])
                begin
                    n_next = n_reg >> 1;
                end
                else
                begin
                    state_next = S_MUL;
                end
            end
            S_MUL:
            begin
                prod_next  = prod_full;
                state_next = S_CHK;
            end
            S_CHK:
            begin
                if (prod_reg <= lim_sel)
                begin
                    n_next     = prod_reg;
                    state_next = S_MUL;
                end
                else if (pidx_reg == P7)
                begin
                    state_next = S_END;
                end
                else
                begin
                    pidx_next  = pidx_reg + 2'd1;
                    state_next = S_MUL;
                end
            end
            S_END:
            begin
                if (n_reg == W'(1) || n_reg == W'(11) || n_reg == W'(13))
                begin
                    fail_next  = 1'b0;
                    state_next = S_DONE;
                end
                else
                begin
                    ext_next   = ext_reg + EW'(1);
                    state_next = S_LOAD;
                end
            end
            S_DONE:
            begin
                if (!out_valid_reg || !out_stall)
                begin
                    out_valid_next  = 1'b1;
                    chosen_next     = fail_reg ? {1'b0, req_reg} : cand;
                    ext_out_next    = fail_reg ? '0 : ext_reg;
                    failed_out_next = fail_reg;
                    state_next      = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            out_valid_reg <= 1'b0;
            pidx_reg      <= P3;
            fail_reg      <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            out_valid_reg <= out_valid_next;
            pidx_reg      <= pidx_next;
            fail_reg      <= fail_next;
        end
    end

    always_ff @(posedge clk)
    begin
        req_reg        <= req_next;
        ext_reg        <= ext_next;
        n_reg          <= n_next;
        prod_reg       <= prod_next;
        chosen_reg     <= chosen_next;
        ext_out_reg    <= ext_out_next;
        failed_out_reg <= failed_out_next;
    end

    assign in_stall      = (state_reg != S_IDLE);
    assign out_valid     = out_valid_reg;
    assign chosen_len    = chosen_reg;
    assign extension     = ext_out_reg;
    assign search_failed = failed_out_reg;

    `FSS_ASSERT_NEXT(a_busy_after_accept, in_valid && !in_stall, in_stall,
        "accepted item did not start a search")
    `FSS_ASSERT_NOW(a_divisor_index, state_reg == S_CHK || state_reg == S_MUL,
        pidx_reg <= P7, "divisor index out of range")
    `FSS_ASSERT_NOW(a_residue_nonzero, state_reg == S_MUL, n_reg != '0,
        "residue fell to zero while dividing")
    `FSS_ASSERT_NOW(a_fail_no_ext, out_valid && search_failed, extension == '0,
        "failed search reports nonzero extension")

endmodule
